[rtl/core/lsld_pkg.sv]
// Shared constants, types and tables of the lidar segment length detector.
// No dependencies; every other file of the block imports this package.
package lsld_pkg;

  // Scan geometry and iteration counts.
  localparam int unsigned MAX_BEAMS    = 2048;
  localparam int unsigned BEAM_W       = $clog2(MAX_BEAMS);
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_MAX   = 24;
  localparam int unsigned ITER_W       = $clog2(CORDIC_MAX);

  // Field and datapath widths.
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned XY_W    = 17;
  localparam int unsigned DIFF_W  = XY_W + 1;
  localparam int unsigned MUL_W   = 18;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned ACC_W   = 36;
  localparam int unsigned Z_W     = 34;
  localparam int unsigned SQ_W    = PROD_W;
  localparam int unsigned ROOT_W  = SQ_W / 2;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned TDATA_W = 48;

  // Fixed-point constants: CORDIC gain 0.6072529 in Q16, output clamp.
  localparam int unsigned GAIN_Q16 = 39797;
  localparam int unsigned XY_LIMIT = 65535;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_RANGE_MIN   = 3'd0,
    REG_RANGE_MAX   = 3'd1,
    REG_ANGLE_START = 3'd2,
    REG_ANGLE_STEP  = 3'd3,
    REG_BREAK_GAP   = 3'd4,
    REG_DIAMETER    = 3'd5,
    REG_TOLERANCE   = 3'd6,
    REG_CONFIRM     = 3'd7
  } cfg_reg_e;

  // Converted point handed from the rotator to the sequencer.
  typedef struct packed {
    logic                    done;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
  } point_t;

endpackage

[rtl/core/lsld_cordic.sv]
// Iterative CORDIC rotator: one shift-add step per cycle, then rounding and clamping.
// Depends on lsld_pkg for widths, the step count and the arctangent table.
module lsld_cordic import lsld_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ACC_W-1:0]         x0_i,
  input  logic [ANGLE_W-1:0]       phase_i,
  output point_t                   pt_o
);

  logic signed [ACC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]   z_q, z_d;
  logic [ITER_W-1:0]       it_q, it_d;
  logic                    flip_q, flip_d;
  logic                    busy_q, busy_d;
  logic                    rnd_q, rnd_d;
  logic                    done_q, done_d;
  logic signed [XY_W-1:0]  xo_q, xo_d, yo_q, yo_d;

  logic                    fold;
  logic [ANGLE_W-1:0]      phase_f;
  logic signed [ACC_W-1:0] xs, ys;
  logic signed [Z_W-1:0]   atan_s;
  logic signed [ACC_W:0]   xr, yr;

  function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] lim;
    lim = (ACC_W+1)'(XY_LIMIT);
    if (v > lim) begin
      sat_xy = XY_W'(lim);
    end else if (v < -lim) begin
      sat_xy = XY_W'(-lim);
    end else begin
      sat_xy = XY_W'(v);
    end
  endfunction

  // Phases in the left half-plane are turned by half a turn and the result negated.
  assign fold    = phase_i[ANGLE_W-1] ^ phase_i[ANGLE_W-2];
  assign phase_f = {phase_i[ANGLE_W-1] ^ fold, phase_i[ANGLE_W-2:0]};

  assign xs     = x_q >>> it_q;
  assign ys     = y_q >>> it_q;
  assign atan_s = signed'(Z_W'(ATAN_TAB[it_q]));

  always_comb begin
    xr = (signed'({x_q[ACC_W-1], x_q}) + (ACC_W+1)'(32768)) >>> 16;
    yr = (signed'({y_q[ACC_W-1], y_q}) + (ACC_W+1)'(32768)) >>> 16;
    if (flip_q) begin
      xr = -xr;
      yr = -yr;
    end
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    it_d   = it_q;
    flip_d = flip_q;
    busy_d = busy_q;
    rnd_d  = 1'b0;
    done_d = 1'b0;
    xo_d   = xo_q;
    yo_d   = yo_q;
    if (start_i) begin
      x_d    = signed'(x0_i);
      y_d    = '0;
      z_d    = Z_W'(signed'({phase_f, 16'h0000}));
      it_d   = '0;
      flip_d = fold;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_s;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_s;
      end
      it_d = it_q + ITER_W'(1);
      if (it_q == ITER_W'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        rnd_d  = 1'b1;
      end
    end else if (rnd_q) begin
      xo_d   = sat_xy(xr);
      yo_d   = sat_xy(yr);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
      flip_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
      done_q <= done_d;
      it_q   <= it_d;
      flip_q <= flip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
    xo_q <= xo_d;
    yo_q <= yo_d;
  end

  assign pt_o.done = done_q;
  assign pt_o.x    = xo_q;
  assign pt_o.y    = yo_q;

endmodule

[rtl/core/lsld_isqrt.sv]
// Iterative integer square root, one result bit per cycle (floor of the root).
// Depends on lsld_pkg for the radicand and root widths.
module lsld_isqrt import lsld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_W-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic [SQ_W-1:0] trial;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  assign trial = res_q + bit_q;

  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = rad_i;
      res_d  = '0;
      bit_d  = SQ_W'(1) << (SQ_W - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

[rtl/core/lidar_segment_length_detector.sv]
// Lidar segment length detector: one range word in, one result word per scan out.
// A kept sample blocks the input from acceptance until its 16 CORDIC steps and 18
// square-root steps are done; a dropped sample only passes the beam bookkeeping state.
// The result word appears in the cycle after the last beam finishes; one result may wait.
// Reset (rst_ni, asynchronous, active low) loads the register defaults and clears the scan
// state and the hit run.
module lidar_segment_length_detector import lsld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [RANGE_W-1:0] s_axis_tdata,   // [15:0] range_mm
  input  logic               s_axis_tlast,   // last_beam
  // Output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata    // [0] cylinder_found, [1] confirmed,
                                             // [9:2] hit_run, [26:10] hit_x_mm,
                                             // [43:27] hit_y_mm, [47:44] zero
);

  // The sequencer walks one kept sample through the shared multiplier, the rotator and
  // the square-root unit. Dropped samples go straight to the beam bookkeeping state.
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_PHASE = 12'b0000_0000_0010,
    S_GAIN  = 12'b0000_0000_0100,
    S_ROT   = 12'b0000_0000_1000,
    S_WAIT  = 12'b0000_0001_0000,
    S_DIFF  = 12'b0000_0010_0000,
    S_SQX   = 12'b0000_0100_0000,
    S_SQY   = 12'b0000_1000_0000,
    S_ROOT  = 12'b0001_0000_0000,
    S_RWAIT = 12'b0010_0000_0000,
    S_SEG   = 12'b0100_0000_0000,
    S_BEAM  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CFG_W-1:0] range_min_q, range_max_q, angle_start_q, angle_step_q;
  logic [CFG_W-1:0] break_gap_q, diameter_q, tolerance_q;
  logic [CNT_W-1:0] confirm_q;

  // Per-word input latches.
  logic [RANGE_W-1:0] range_q;
  logic               last_q;

  // Scan state.
  logic [BEAM_W-1:0]      beam_q, beam_d;
  logic signed [XY_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                   have_prev_q, have_prev_d;
  logic                   in_seg_q, in_seg_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   hit_q, hit_d;
  logic signed [XY_W-1:0] hit_x_q, hit_x_d, hit_y_q, hit_y_d;
  logic [CNT_W-1:0]       run_q, run_d;

  // Datapath registers.
  logic [PROD_W-1:0]        prod_q, prod_d, acc_q, acc_d;
  logic [ANGLE_W-1:0]       phase_q, phase_d;
  logic signed [DIFF_W-1:0] dx_q, dx_d, dy_q, dy_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [TDATA_W-1:0] out_data_q, out_data_d;

  // Shared multiplier operands.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  point_t            pt;
  logic              rot_start, root_start, root_done;
  logic [ROOT_W-1:0] gap;

  logic                     in_accept, keep;
  logic signed [XY_W-1:0]   ref_x, ref_y;
  logic [LEN_W:0]           len_sum;
  logic signed [LEN_W+1:0]  len_s, lo_s, hi_s;
  logic [CNT_W-1:0]         run_inc;
  logic                     conf;
  logic                     out_free;

  // The rotator converts the kept range into x,y at the computed beam angle.
  lsld_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rot_start),
    .x0_i    (prod_q),
    .phase_i (phase_q),
    .pt_o    (pt)
  );

  // The root unit turns the squared gap into a distance in millimetres.
  lsld_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (acc_q + prod_q),
    .done_o  (root_done),
    .root_o  (gap)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  // A sample is processed only inside the open window and before a hit in this scan.
  assign keep          = !hit_q && (s_axis_tdata > range_min_q) && (s_axis_tdata < range_max_q);
  assign rot_start     = (state_q == S_ROT);
  assign root_start    = (state_q == S_ROOT);
  assign out_free      = !out_valid_q || m_axis_tready;

  // One signed multiplier serves the beam phase, the CORDIC pre-gain and both squares.
  always_comb begin
    unique case (state_q)
      S_PHASE: begin
        mul_a = signed'(MUL_W'(beam_q));
        mul_b = signed'(MUL_W'(angle_step_q));
      end
      S_GAIN: begin
        mul_a = signed'(MUL_W'(range_q));
        mul_b = signed'(MUL_W'(GAIN_Q16));
      end
      S_SQX: begin
        mul_a = dx_q;
        mul_b = dx_q;
      end
      S_SQY: begin
        mul_a = dy_q;
        mul_b = dy_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // The first kept point of a scan is its own predecessor, so its gap is zero.
  assign ref_x = have_prev_q ? prev_x_q : pt.x;
  assign ref_y = have_prev_q ? prev_y_q : pt.y;

  // Segment length bookkeeping and the acceptance window diameter plus or minus tolerance.
  assign len_sum = (in_seg_q ? {1'b0, len_q} : '0) + (LEN_W+1)'(gap);
  assign len_s   = signed'((LEN_W+2)'(len_q));
  assign lo_s    = signed'((LEN_W+2)'(diameter_q)) - signed'((LEN_W+2)'(tolerance_q));
  assign hi_s    = signed'((LEN_W+2)'(diameter_q)) + signed'((LEN_W+2)'(tolerance_q));

  assign run_inc = run_q + CNT_W'(1);
  assign conf    = hit_q && (run_q != '1) && (run_inc == confirm_q);

  always_comb begin
    state_d     = state_q;
    beam_d      = beam_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    have_prev_d = have_prev_q;
    in_seg_d    = in_seg_q;
    len_d       = len_q;
    hit_d       = hit_q;
    hit_x_d     = hit_x_q;
    hit_y_d     = hit_y_q;
    run_d       = run_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    phase_d     = phase_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = keep ? S_PHASE : S_BEAM;
        end
      end
      S_PHASE: begin
        prod_d  = PROD_W'(mul_p);
        state_d = S_GAIN;
      end
      S_GAIN: begin
        phase_d = angle_start_q + prod_q[ANGLE_W-1:0];
        prod_d  = PROD_W'(mul_p);
        state_d = S_ROT;
      end
      S_ROT: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (pt.done) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        dx_d    = DIFF_W'(pt.x) - DIFF_W'(ref_x);
        dy_d    = DIFF_W'(pt.y) - DIFF_W'(ref_y);
        state_d = S_SQX;
      end
      S_SQX: begin
        prod_d  = PROD_W'(mul_p);
        state_d = S_SQY;
      end
      S_SQY: begin
        acc_d   = prod_q;
        prod_d  = PROD_W'(mul_p);
        state_d = S_ROOT;
      end
      S_ROOT: begin
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        if (root_done) begin
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        if (gap < ROOT_W'(break_gap_q)) begin
          in_seg_d = 1'b1;
          len_d    = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
        end else if (in_seg_q) begin
          // A segment closes here: latch a hit when its length falls inside the window.
          if ((len_s > lo_s) && (len_s < hi_s)) begin
            hit_d   = 1'b1;
            hit_x_d = pt.x;
            hit_y_d = pt.y;
          end
          in_seg_d = 1'b0;
          len_d    = '0;
        end
        prev_x_d    = pt.x;
        prev_y_d    = pt.y;
        have_prev_d = 1'b1;
        state_d     = S_BEAM;
      end
      S_BEAM: begin
        if (!last_q) begin
          if (beam_q != BEAM_W'(MAX_BEAMS - 1)) begin
            beam_d = beam_q + BEAM_W'(1);
          end
          state_d = S_IDLE;
        end else if (out_free) begin
          // End of scan: report, update the hit run and start a fresh scan.
          if (hit_q) begin
            if (run_q != '1) begin
              run_d = run_inc;
            end
          end else begin
            run_d = '0;
          end
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[0]     = hit_q;
          out_data_d[1]     = conf;
          out_data_d[9:2]   = hit_q ? ((run_q != '1) ? run_inc : run_q) : '0;
          out_data_d[26:10] = hit_q ? hit_x_q : '0;
          out_data_d[43:27] = hit_q ? hit_y_q : '0;
          beam_d      = '0;
          prev_x_d    = '0;
          prev_y_d    = '0;
          have_prev_d = 1'b0;
          in_seg_d    = 1'b0;
          len_d       = '0;
          hit_d       = 1'b0;
          hit_x_d     = '0;
          hit_y_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration writes; only the low bits of the data are used by the narrow register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q   <= CFG_W'(100);
      range_max_q   <= CFG_W'(30000);
      angle_start_q <= CFG_W'(32768);
      angle_step_q  <= CFG_W'(182);
      break_gap_q   <= CFG_W'(100);
      diameter_q    <= CFG_W'(300);
      tolerance_q   <= CFG_W'(50);
      confirm_q     <= CNT_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RANGE_MIN:   range_min_q   <= cfg_data_i;
        REG_RANGE_MAX:   range_max_q   <= cfg_data_i;
        REG_ANGLE_START: angle_start_q <= cfg_data_i;
        REG_ANGLE_STEP:  angle_step_q  <= cfg_data_i;
        REG_BREAK_GAP:   break_gap_q   <= cfg_data_i;
        REG_DIAMETER:    diameter_q    <= cfg_data_i;
        REG_TOLERANCE:   tolerance_q   <= cfg_data_i;
        REG_CONFIRM:     confirm_q     <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      beam_q      <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      in_seg_q    <= 1'b0;
      len_q       <= '0;
      hit_q       <= 1'b0;
      hit_x_q     <= '0;
      hit_y_q     <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      beam_q      <= beam_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      have_prev_q <= have_prev_d;
      in_seg_q    <= in_seg_d;
      len_q       <= len_d;
      hit_q       <= hit_d;
      hit_x_q     <= hit_x_d;
      hit_y_q     <= hit_y_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      range_q <= s_axis_tdata;
      last_q  <= s_axis_tlast;
    end
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    phase_q    <= phase_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[bench/tb_lidar_segment_length_detector.sv]
// Self-checking testbench for the lidar segment length detector.
// Depends on lsld_pkg and the lidar_segment_length_detector top level only.
module tb_lidar_segment_length_detector;
  import lsld_pkg::*;

  localparam int     RESET_CYCLES  = 9;
  localparam int     HOLD_CYCLES   = 4000;
  // A kept sample keeps the block busy without any result word, so every register
  // update first waits for it to finish once the bench is drained.
  localparam int     SETTLE_CYCLES = 60;
  localparam longint CYCLE_LIMIT   = 1000000;
  localparam longint LEN_CAP       = (longint'(1) << LEN_W) - 1;

  // One beam as it travels on the input stream.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               last;
  } beam_t;

  // One scan result as it travels on the output stream.
  typedef struct packed {
    logic                   found;
    logic                   confirmed;
    logic [CNT_W-1:0]       run;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } scan_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [2:0]         cfg_idx_i     = REG_RANGE_MIN;
  logic [CFG_W-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [RANGE_W-1:0] s_axis_tdata  = '0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;

  lidar_segment_length_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] range_mm
    .s_axis_tlast  (s_axis_tlast),   // last_beam
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [0] cylinder_found, [1] confirmed, [9:2] hit_run,
                                     // [26:10] hit_x_mm, [43:27] hit_y_mm, [47:44] zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Beams waiting to be offered, and scan results that the predictor has worked out
  // but the block has not yet delivered.
  beam_t        pending_beams[$];
  scan_result_t expected_scans[$];

  int     mismatch_count = 0;
  longint cycle_count    = 0;
  int     tx_idle_pct    = 0;
  int     rx_idle_pct    = 0;
  bit     hold_go        = 1'b0;
  logic   rx_hold        = 1'b0;
  logic   bus_free;
  beam_t  next_beam;

  // Bench copy of the configuration registers.
  logic [CFG_W-1:0] cur_range_min, cur_range_max, cur_angle_start, cur_angle_step;
  logic [CFG_W-1:0] cur_break_gap, cur_diameter, cur_tolerance;
  logic [CNT_W-1:0] cur_confirm;
  logic [CFG_W-1:0] next_cfg [8];

  // Bench copy of the scan state.
  logic [BEAM_W-1:0]      scan_beam;
  logic signed [XY_W-1:0] last_x, last_y;
  logic                   last_valid, seg_open, target_seen;
  longint                 seg_len;
  logic signed [XY_W-1:0] target_x, target_y;
  logic [CNT_W-1:0]       hit_streak;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic signed [XY_W-1:0] clamp_xy(input longint v);
    longint lim;
    lim = XY_LIMIT;
    if (v > lim) return XY_W'(lim);
    if (v < -lim) return XY_W'(-lim);
    return XY_W'(v);
  endfunction

  // Floor of the square root; the double estimate is nudged onto the exact value.
  function automatic longint int_root(input longint v);
    longint r;
    real    rv;
    rv = v;
    r  = $rtoi($sqrt(rv));
    while (r * r > v) r = r - 1;
    while ((r + 1) * (r + 1) <= v) r = r + 1;
    return r;
  endfunction

  // Polar to Cartesian by CORDIC rotation. The left half plane is folded over by a
  // half turn first and the result negated afterwards.
  task automatic beam_to_point(input logic [RANGE_W-1:0] rng, input logic [ANGLE_W-1:0] phase,
                               output logic signed [XY_W-1:0] px,
                               output logic signed [XY_W-1:0] py);
    longint             x, y, z, nx;
    logic [ANGLE_W-1:0] p;
    logic               flip;
    int                 i;
    p    = phase;
    flip = 1'b0;
    if (p >= 16'd16384 && p < 16'd49152) begin
      flip = 1'b1;
      p    = p + 16'd32768;
    end
    z = p[ANGLE_W-1] ? longint'(p) - 65536 : longint'(p);
    z = z * 65536;
    x = longint'(rng) * longint'(GAIN_Q16);
    y = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    if (flip) begin
      x = -x;
      y = -y;
    end
    px = clamp_xy(x);
    py = clamp_xy(y);
  endtask

  task automatic start_new_scan();
    scan_beam   = '0;
    last_x      = '0;
    last_y      = '0;
    last_valid  = 1'b0;
    seg_open    = 1'b0;
    seg_len     = 0;
    target_seen = 1'b0;
    target_x    = '0;
    target_y    = '0;
  endtask

  // Advances the bench copy of the scan by one accepted beam and, on the last beam of a
  // scan, queues the result word that the block must deliver.
  task automatic predict_beam(input logic [RANGE_W-1:0] rng, input logic last);
    logic signed [XY_W-1:0] px, py;
    logic [ANGLE_W-1:0]     phase;
    longint                 dx, dy, gap, lo_lim, hi_lim;
    scan_result_t           res;
    if (!target_seen && rng > cur_range_min && rng < cur_range_max) begin
      phase = cur_angle_start + scan_beam * cur_angle_step;
      beam_to_point(rng, phase, px, py);
      // A first kept point has a zero gap, so it opens a segment if cur_break_gap > 0.
      if (!last_valid) begin
        last_x     = px;
        last_y     = py;
        last_valid = 1'b1;
      end
      dx  = longint'(px) - longint'(last_x);
      dy  = longint'(py) - longint'(last_y);
      gap = int_root(dx * dx + dy * dy);
      if (gap < longint'(cur_break_gap)) begin
        if (!seg_open) begin
          seg_open = 1'b1;
          seg_len  = 0;
        end
        seg_len = seg_len + gap;
        if (seg_len > LEN_CAP) seg_len = LEN_CAP;
      end else if (seg_open) begin
        lo_lim = longint'(cur_diameter) - longint'(cur_tolerance);
        hi_lim = longint'(cur_diameter) + longint'(cur_tolerance);
        if (seg_len > lo_lim && seg_len < hi_lim) begin
          target_seen = 1'b1;
          target_x    = px;
          target_y    = py;
        end
        seg_open = 1'b0;
        seg_len  = 0;
      end
      last_x = px;
      last_y = py;
    end
    if (scan_beam < MAX_BEAMS - 1) scan_beam = scan_beam + 1'b1;
    if (last) begin
      // The run saturates, and the confirm flag only fires on a scan that moved it.
      res.confirmed = 1'b0;
      if (target_seen) begin
        if (hit_streak < 8'd255) begin
          hit_streak    = hit_streak + 1'b1;
          res.confirmed = (hit_streak == cur_confirm);
        end
      end else begin
        hit_streak = '0;
      end
      res.found = target_seen;
      res.run   = hit_streak;
      res.x     = target_seen ? target_x : '0;
      res.y     = target_seen ? target_y : '0;
      expected_scans = {expected_scans, res};
      start_new_scan();
    end
  endtask

  task automatic check_scan_word(input logic [TDATA_W-1:0] w);
    scan_result_t want;
    if (expected_scans.size() == 0) begin
      report_mismatch("result word with no scan pending", 1, 0);
      return;
    end
    want = expected_scans.pop_front();
    if (w[0] !== want.found)         report_mismatch("cylinder_found", w[0], want.found);
    if (w[1] !== want.confirmed)     report_mismatch("confirmed", w[1], want.confirmed);
    if (w[9:2] !== want.run)         report_mismatch("hit_run", w[9:2], want.run);
    if (w[26:10] !== want.x)         report_mismatch("hit_x_mm", $signed(w[26:10]), want.x);
    if (w[43:27] !== want.y)         report_mismatch("hit_y_mm", $signed(w[43:27]), want.y);
    if (w[TDATA_W-1:44] !== '0)      report_mismatch("padding", w[TDATA_W-1:44], 0);
  endtask

  // Input driver. The predictor runs on the word that the edge has just accepted, so
  // it always sees the configuration that the block saw. A held word is never dropped.
  always @(posedge clk_i) begin
    bus_free = !s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      predict_beam(s_axis_tdata, s_axis_tlast);
      bus_free = 1'b1;
    end
    if (bus_free) begin
      if (rst_ni && pending_beams.size() > 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        next_beam = pending_beams.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_beam.range_mm;
        s_axis_tlast  <= next_beam.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor with a randomly stalling receiver.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_scan_word(m_axis_tdata);
    m_axis_tready <= rst_ni && !rx_hold && ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // One long receiver hold-off, so that results back up and the block stalls its input
  // while the sender keeps offering words.
  initial begin
    while (!hold_go) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lidar_segment_length_detector: FAILED **");
      $finish;
    end
  end

  task automatic push_beam(input logic [RANGE_W-1:0] rng, input logic last);
    beam_t b;
    b.range_mm = rng;
    b.last     = last;
    pending_beams = {pending_beams, b};
  endtask

  // A range drawn to hit the window edges and the word's extremes as often as its middle.
  function automatic logic [RANGE_W-1:0] noise_range();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return cur_range_min;
      4:       return cur_range_max;
      default: begin
        if (int'(cur_range_max) > int'(cur_range_min) + 1)
          return $urandom_range(int'(cur_range_max) - 1, int'(cur_range_min) + 1);
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [RANGE_W-1:0] maybe_noisy(input int unsigned rng);
    if ($urandom_range(99, 0) < 8) return noise_range();
    return rng;
  endfunction

  task automatic queue_noise_scan();
    int n, b;
    n = $urandom_range(12, 1);
    for (b = 0; b < n; b++) push_beam(noise_range(), b == n - 1);
  endtask

  // A scan shaped like a real target: background, then a run of beams at one range whose
  // arc length is close to the diameter, then background again to break the segment.
  task automatic queue_shaped_scan();
    int unsigned lo_r, hi_r, se, ro, bg, ro_cap;
    int          k, npre, npost, b;
    real         g, rc, rr;
    if (int'(cur_range_max) < int'(cur_range_min) + 3) begin
      queue_noise_scan();
      return;
    end
    lo_r = cur_range_min + 1;
    hi_r = cur_range_max - 1;
    se   = (cur_angle_step <= 16'd32768) ? cur_angle_step : 32'd65536 - cur_angle_step;
    if (se == 0) begin
      ro_cap = hi_r;
    end else begin
      rr = se;
      rc = cur_break_gap;
      rc = rc * 65536.0 / (rr * 6.2832) * 0.85;
      if (rc >= hi_r) ro_cap = hi_r;
      else if (rc <= lo_r) ro_cap = lo_r;
      else ro_cap = $rtoi(rc);
    end
    ro = $urandom_range(ro_cap, lo_r);
    rr = ro;
    g  = rr * se * 6.2832 / 65536.0;
    if (g > 0.5) begin
      rc = cur_diameter;
      k  = $rtoi(rc / g + 1.5);
    end else begin
      k = $urandom_range(8, 2);
    end
    k = k + $urandom_range(2, 0) - 1;
    if (k < 1) k = 1;
    if (k > 30) k = 30;
    if ($urandom_range(1, 0)) bg = (2 * ro + cur_break_gap > hi_r) ? hi_r : 2 * ro + cur_break_gap;
    else bg = (ro / 2 > lo_r) ? ro / 2 : lo_r;
    npre  = $urandom_range(3, 0);
    npost = $urandom_range(3, 1);
    for (b = 0; b < npre; b++) push_beam(maybe_noisy(bg), 1'b0);
    for (b = 0; b < k; b++) push_beam(maybe_noisy(ro + $urandom_range(2, 0)), 1'b0);
    for (b = 0; b < npost; b++) push_beam(maybe_noisy(bg), b == npost - 1);
  endtask

  task automatic queue_scans(input int n, input int noise_pct);
    int s;
    for (s = 0; s < n; s++) begin
      if ($urandom_range(99, 0) < noise_pct) queue_noise_scan();
      else queue_shaped_scan();
    end
  endtask

  // Waits for the sender to drain and every expected result to arrive, then lets the
  // last kept sample finish before anything is reconfigured.
  task automatic wait_idle();
    while (pending_beams.size() != 0 || s_axis_tvalid || expected_scans.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all eight registers from next_cfg on consecutive edges; the block is idle.
  task automatic apply_settings();
    int i;
    wait_idle();
    for (i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= next_cfg[i];
      case (cfg_reg_e'(i))
        REG_RANGE_MIN:   cur_range_min   = next_cfg[i];
        REG_RANGE_MAX:   cur_range_max   = next_cfg[i];
        REG_ANGLE_START: cur_angle_start = next_cfg[i];
        REG_ANGLE_STEP:  cur_angle_step  = next_cfg[i];
        REG_BREAK_GAP:   cur_break_gap   = next_cfg[i];
        REG_DIAMETER:    cur_diameter    = next_cfg[i];
        REG_TOLERANCE:   cur_tolerance   = next_cfg[i];
        REG_CONFIRM:     cur_confirm     = next_cfg[i][CNT_W-1:0];
        default: ;
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_cfg(input int rmin, input int rmax, input int start, input int step,
                         input int gap, input int diam, input int tol, input int conf);
    next_cfg[REG_RANGE_MIN]   = rmin;
    next_cfg[REG_RANGE_MAX]   = rmax;
    next_cfg[REG_ANGLE_START] = start;
    next_cfg[REG_ANGLE_STEP]  = step;
    next_cfg[REG_BREAK_GAP]   = gap;
    next_cfg[REG_DIAMETER]    = diam;
    next_cfg[REG_TOLERANCE]   = tol;
    next_cfg[REG_CONFIRM]     = conf;
  endtask

  // Plausible random settings; now and then the start angle sits on a quadrant fold and
  // the step runs backwards, so scans sweep across the half-turn boundaries.
  task automatic rand_settings();
    int start, step;
    start = $urandom_range(65535, 0);
    if ($urandom_range(3, 0) == 0) begin
      case ($urandom_range(3, 0))
        0:       start = 16383;
        1:       start = 16384;
        2:       start = 49151;
        default: start = 49152;
      endcase
    end
    step = $urandom_range(800, 40);
    if ($urandom_range(4, 0) == 0) step = 65536 - step;
    set_cfg($urandom_range(400, 0), $urandom_range(65535, 8000), start, step,
            $urandom_range(300, 40), $urandom_range(700, 100), $urandom_range(120, 10),
            $urandom_range(6, 1));
  endtask

  initial begin
    int          s;
    int unsigned r;
    // Register defaults and an empty scan, as after reset.
    cur_range_min   = 16'd100;
    cur_range_max   = 16'd30000;
    cur_angle_start = 16'd32768;
    cur_angle_step  = 16'd182;
    cur_break_gap   = 16'd100;
    cur_diameter    = 16'd300;
    cur_tolerance   = 16'd50;
    cur_confirm     = 8'd5;
    hit_streak      = '0;
    start_new_scan();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First third: the sender idles now and then, the receiver more often.
    tx_idle_pct = 33;
    rx_idle_pct = 51;

    // Directed scans under the reset defaults. An empty scan that counts as a miss.
    push_beam(16'd0, 1'b1);
    // Window edges and range extremes, then five beams at 4300 mm (about 75 mm apart at
    // one degree per beam) whose four gaps sum to about 300 mm. The 1000 mm beam breaks
    // the segment and latches the hit; the beam after it is ignored.
    push_beam(16'd101, 1'b0);
    push_beam(16'd29999, 1'b0);
    push_beam(16'd100, 1'b0);
    push_beam(16'd30000, 1'b0);
    push_beam(16'hFFFF, 1'b0);
    for (s = 0; s < 5; s++) push_beam(16'd4300, 1'b0);
    push_beam(16'd1000, 1'b0);
    push_beam(16'd4300, 1'b0);
    push_beam(16'd0, 1'b1);
    // A segment of the right length that is still open at the end of the scan is a miss.
    for (s = 0; s < 5; s++) push_beam(16'd4300, s == 4);
    push_beam(16'hFFFF, 1'b1);

    // Random settings; the receiver stops for a long stretch at the start of the phase.
    rand_settings();
    apply_settings();
    hold_go = 1'b1;
    queue_scans(12, 20);
    rand_settings();
    apply_settings();
    queue_scans(12, 20);

    // Second third: the idling is turned round.
    tx_idle_pct = 51;
    rx_idle_pct = 33;

    // Register extremes. Any closing segment shorter than 65535 mm counts as a hit here.
    set_cfg(0, 65535, 0, 65535, 65535, 0, 65535, 254);
    apply_settings();
    queue_scans(8, 50);
    // Breaking distance of zero, so no segment can ever open.
    set_cfg(0, 65535, 65535, 1, 0, 65535, 0, 1);
    apply_settings();
    queue_scans(5, 50);
    // Empty range window: every sample is dropped.
    set_cfg(65535, 0, 65535, 0, 0, 0, 65535, 1);
    apply_settings();
    queue_scans(5, 50);
    // A confirm count of zero must never fire.
    rand_settings();
    next_cfg[REG_CONFIRM] = 0;
    apply_settings();
    queue_scans(12, 20);

    // Last third: no idling at all.
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // Two-beam scans that always hit: the first point opens a zero-length segment and
    // the second closes it. Enough of them to confirm at 254 and saturate the run.
    set_cfg(100, 30000, $urandom_range(65535, 0), 182, 1, 0, 10, 254);
    apply_settings();
    for (s = 0; s < 258; s++) begin
      r = $urandom_range(5000, 500);
      push_beam(RANGE_W'(r), 1'b0);
      push_beam(RANGE_W'(r + $urandom_range(2000, 200)), 1'b1);
    end

    for (s = 0; s < 2; s++) begin
      rand_settings();
      apply_settings();
      queue_scans(12, 20);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("** lidar_segment_length_detector: PASSED **");
    end else begin
      $display("** lidar_segment_length_detector: FAILED **");
    end
    $finish;
  end

endmodule
